/* hdl/rtu_pkg.sv */
package rtu_pkg;

  // Parse phase codes
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_HALT   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_END     = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // Radix mode register codes
  localparam logic [1:0] RADIX_BIN   = 2'd0;
  localparam logic [1:0] RADIX_DEC   = 2'd1;
  localparam logic [1:0] RADIX_HEX   = 2'd2;
  localparam logic [1:0] RADIX_UNSUP = 2'd3;

  localparam logic [1:0] RADIX_RESET = RADIX_DEC;

  // Characters of interest
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_F    = 8'h46;
  localparam logic [7:0] CH_LC_X    = 8'h78;
  localparam logic [7:0] CH_UC_X    = 8'h58;

  localparam int VALUE_BITS      = 32;
  localparam int STOP_BITS       = 16;
  localparam int OFFSET_BITS_DEF = 16;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [STOP_BITS-1:0]  offset;
    logic [1:0]            status;
  } result_t;

endpackage

/* hdl/radix_text_to_unsigned_top.sv */
// Streaming text-to-unsigned converter. Feed the bytes of a NUL-terminated
// string on text_byte_i, one transaction each; the NUL byte yields exactly one
// result transaction (value, stop offset, status) and every other byte yields
// none. Leading '0' characters are skipped, an 'x'/'X' prefix is taken only in
// hex mode, digits of the selected radix accumulate modulo 2^32, and the first
// bad byte freezes the result until the NUL. The block takes one byte per
// cycle while in_stall_o is low, and out_valid_o is registered; the per-byte
// update is a single shift or multiply-by-ten-and-add on the parse registers.
// A two-entry output buffer (output register plus skid slot) lets input keep
// flowing while a result waits; in_stall_o rises only when both entries hold
// results. Write radix_mode only while no string is in flight.
module radix_text_to_unsigned_top #(
  parameter int OFFSET_BITS = rtu_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_radix_mode_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] parsed_value_o,
  output logic [15:0] stop_offset_o,
  output logic [1:0]  parse_status_o
);

  logic [1:0]                     radix_q;
  logic [1:0]                     phase_q, phase_d;
  logic [rtu_pkg::VALUE_BITS-1:0] value_q, value_d;
  logic [OFFSET_BITS-1:0]         index_q, index_d;
  logic [OFFSET_BITS-1:0]         held_off_q, held_off_d;
  logic [1:0]                     held_status_q, held_status_d;
  logic                           emit;
  rtu_pkg::result_t               result;

  // output register and skid slot
  logic             out_valid_q;
  rtu_pkg::result_t out_q;
  logic             skid_valid_q;
  rtu_pkg::result_t skid_q;

  logic in_fire;
  logic out_fire;
  logic new_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign new_res     = in_fire && emit;

  rtu_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .radix_mode_i  (radix_q),
    .text_byte_i   (text_byte_i),
    .phase_i       (phase_q),
    .value_i       (value_q),
    .index_i       (index_q),
    .held_off_i    (held_off_q),
    .held_status_i (held_status_q),
    .phase_o       (phase_d),
    .value_o       (value_d),
    .index_o       (index_d),
    .held_off_o    (held_off_d),
    .held_status_o (held_status_d),
    .emit_o        (emit),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rtu_pkg::RADIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_radix_mode_i;
    end
  end

  // parse state advances on every accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= rtu_pkg::PH_SKIP;
      value_q       <= '0;
      index_q       <= '0;
      held_off_q    <= '0;
      held_status_q <= rtu_pkg::ST_END;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      value_q       <= value_d;
      index_q       <= index_d;
      held_off_q    <= held_off_d;
      held_status_q <= held_status_d;
    end
  end

  // Output buffer: a new result goes to the output register when it is
  // free (or drains this cycle) and the skid slot is empty; otherwise it
  // parks in the skid slot, which refills the output register on drain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (new_res && out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end
      if (out_fire || !out_valid_q) begin
        out_valid_q <= skid_valid_q || new_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : result;
    end
    if (!skid_valid_q && new_res && out_valid_q && !out_fire) begin
      skid_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parsed_value_o = out_q.value;
  assign stop_offset_o  = out_q.offset;
  assign parse_status_o = out_q.status;

endmodule

/* hdl/rtu_parse.sv */
module rtu_parse #(
  parameter int OFFSET_BITS = rtu_pkg::OFFSET_BITS_DEF
) (
  input  logic [1:0]                      radix_mode_i,
  input  logic [7:0]                      text_byte_i,
  input  logic [1:0]                      phase_i,
  input  logic [rtu_pkg::VALUE_BITS-1:0]  value_i,
  input  logic [OFFSET_BITS-1:0]          index_i,
  input  logic [OFFSET_BITS-1:0]          held_off_i,
  input  logic [1:0]                      held_status_i,
  output logic [1:0]                      phase_o,
  output logic [rtu_pkg::VALUE_BITS-1:0]  value_o,
  output logic [OFFSET_BITS-1:0]          index_o,
  output logic [OFFSET_BITS-1:0]          held_off_o,
  output logic [1:0]                      held_status_o,
  output logic                            emit_o,
  output rtu_pkg::result_t                result_o
);

  logic                           is_dec;
  logic                           is_lc_hex;
  logic                           is_uc_hex;
  logic                           is_bin;
  logic                           digit_ok;
  logic [3:0]                     digit;
  logic [rtu_pkg::VALUE_BITS-1:0] acc;
  logic [OFFSET_BITS-1:0]         index_inc;
  logic [OFFSET_BITS-1:0]         end_off;
  logic [rtu_pkg::STOP_BITS-1:0]  end_off_clip;

  assign is_dec    = (text_byte_i >= rtu_pkg::CH_ZERO) && (text_byte_i <= rtu_pkg::CH_NINE);
  assign is_lc_hex = (text_byte_i >= rtu_pkg::CH_LC_A) && (text_byte_i <= rtu_pkg::CH_LC_F);
  assign is_uc_hex = (text_byte_i >= rtu_pkg::CH_UC_A) && (text_byte_i <= rtu_pkg::CH_UC_F);
  assign is_bin    = (text_byte_i == rtu_pkg::CH_ZERO) || (text_byte_i == rtu_pkg::CH_ONE);

  // letters: low nibble 1..6 maps to 10..15
  assign digit = is_dec ? text_byte_i[3:0] : 4'(text_byte_i[3:0] + 4'd9);

  always_comb begin
    case (radix_mode_i)
      rtu_pkg::RADIX_BIN: begin
        digit_ok = is_bin;
        acc      = {value_i[rtu_pkg::VALUE_BITS-2:0], digit[0]};
      end
      rtu_pkg::RADIX_DEC: begin
        digit_ok = is_dec;
        acc      = (value_i << 3) + (value_i << 1) + rtu_pkg::VALUE_BITS'(digit);
      end
      rtu_pkg::RADIX_HEX: begin
        digit_ok = is_dec || is_lc_hex || is_uc_hex;
        acc      = {value_i[rtu_pkg::VALUE_BITS-5:0], digit};
      end
      default: begin
        digit_ok = 1'b0;
        acc      = value_i;
      end
    endcase
  end

  assign index_inc = (index_i != {OFFSET_BITS{1'b1}}) ? OFFSET_BITS'(index_i + 1'b1) : index_i;

  assign end_off = (phase_i == rtu_pkg::PH_HALT) ? held_off_i : index_i;

  generate
    if (OFFSET_BITS > rtu_pkg::STOP_BITS) begin : g_clip
      assign end_off_clip = (|end_off[OFFSET_BITS-1:rtu_pkg::STOP_BITS]) ?
                            {rtu_pkg::STOP_BITS{1'b1}} : end_off[rtu_pkg::STOP_BITS-1:0];
    end else begin : g_ext
      assign end_off_clip = rtu_pkg::STOP_BITS'(end_off);
    end
  endgenerate

  always_comb begin
    phase_o       = phase_i;
    value_o       = value_i;
    index_o       = index_inc;
    held_off_o    = held_off_i;
    held_status_o = held_status_i;
    emit_o        = 1'b0;
    result_o      = '0;

    if (text_byte_i == rtu_pkg::CH_NUL) begin
      emit_o = 1'b1;
      if (radix_mode_i == rtu_pkg::RADIX_UNSUP) begin
        result_o.value  = '0;
        result_o.offset = '0;
        result_o.status = rtu_pkg::ST_REJECT;
      end else if (phase_i == rtu_pkg::PH_HALT) begin
        result_o.value  = value_i;
        result_o.offset = end_off_clip;
        result_o.status = held_status_i;
      end else begin
        result_o.value  = value_i;
        result_o.offset = end_off_clip;
        result_o.status = rtu_pkg::ST_END;
      end
      // back to the start for the next string
      phase_o       = rtu_pkg::PH_SKIP;
      value_o       = '0;
      index_o       = '0;
      held_off_o    = '0;
      held_status_o = rtu_pkg::ST_END;
    end else if (phase_i != rtu_pkg::PH_HALT) begin
      if (radix_mode_i == rtu_pkg::RADIX_UNSUP) begin
        phase_o       = rtu_pkg::PH_HALT;
        held_status_o = rtu_pkg::ST_REJECT;
        held_off_o    = '0;
        value_o       = '0;
      end else if ((phase_i == rtu_pkg::PH_SKIP) && (text_byte_i == rtu_pkg::CH_ZERO)) begin
        // leading zero
      end else if ((phase_i == rtu_pkg::PH_SKIP) &&
                   ((text_byte_i == rtu_pkg::CH_LC_X) || (text_byte_i == rtu_pkg::CH_UC_X))) begin
        if (radix_mode_i == rtu_pkg::RADIX_HEX) begin
          phase_o = rtu_pkg::PH_DIGITS;
        end else begin
          phase_o       = rtu_pkg::PH_HALT;
          held_status_o = rtu_pkg::ST_REJECT;
          held_off_o    = index_i;
          value_o       = '0;
        end
      end else if (digit_ok) begin
        phase_o = rtu_pkg::PH_DIGITS;
        value_o = acc;
      end else begin
        phase_o       = rtu_pkg::PH_HALT;
        held_status_o = rtu_pkg::ST_INVALID;
        held_off_o    = index_i;
      end
    end
  end

endmodule
